>>> design/session_lifecycle_sequencer_top_defines.svh
// assertion macros for the session lifecycle sequencer
`ifndef SESSION_LIFECYCLE_SEQUENCER_TOP_DEFINES_SVH
`define SESSION_LIFECYCLE_SEQUENCER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SLS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLS_ASSERT(label, clk, rst_n, prop, msg)
`define SLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> design/sls_pkg.sv
// shared types and constants of the session lifecycle sequencer
`default_nettype none
package sls_pkg;
  localparam int unsigned SeqWidthDefault = 64;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [3:0] {
    EV_LOGON_REQ = 4'd0, EV_LOGON_ACC = 4'd1, EV_LOGOFF_REQ = 4'd2,
    EV_LOGOFF_DONE = 4'd3, EV_REC_BEGIN = 4'd4, EV_REC_DONE = 4'd5,
    EV_HALT = 4'd6, EV_SHUTDOWN = 4'd7, EV_CLAIM = 4'd8,
    EV_OBSERVE = 4'd9, EV_HB_CHECK = 4'd10
  } event_e;

  typedef enum logic [2:0] {
    ST_STOPPED = 3'd0, ST_STARTING = 3'd1, ST_LOGGING_ON = 3'd2,
    ST_ACTIVE = 3'd3, ST_RECOVERING = 3'd4, ST_HALTED = 3'd5,
    ST_LOGGING_OFF = 3'd6
  } sess_state_e;

  localparam logic [3:0] RS_NONE = 4'd0;
  localparam logic [3:0] RS_OP_START = 4'd1;
  localparam logic [3:0] RS_LOGON_ACC = 4'd2;
  localparam logic [3:0] RS_OP_LOGOFF = 4'd3;
  localparam logic [3:0] RS_LOGOFF_DONE = 4'd4;
  localparam logic [3:0] RS_REC_DONE = 4'd5;
  localparam logic [3:0] RS_SHUTDOWN = 4'd6;
  localparam logic [3:0] RS_SEQ_GAP = 4'd7;
  localparam logic [3:0] RS_HB_TIMEOUT = 4'd8;

  localparam logic [2:0] SQ_IN_ORDER = 3'd0;
  localparam logic [2:0] SQ_FIRST = 3'd1;
  localparam logic [2:0] SQ_DUPLICATE = 3'd2;
  localparam logic [2:0] SQ_OUT_OF_ORDER = 3'd3;
  localparam logic [2:0] SQ_GAP = 3'd4;
  localparam logic [2:0] SQ_INVALID = 3'd5;
  localparam logic [2:0] SQ_EXHAUSTED = 3'd6;

  localparam logic [1:0] CFG_EPOCH = 2'd0;
  localparam logic [1:0] CFG_FENCE = 2'd1;
  localparam logic [1:0] CFG_HB_INTERVAL = 2'd2;
  localparam logic [1:0] CFG_HB_TIMEOUT = 2'd3;

  // classified event handed from front to back
  typedef struct packed {
    logic [3:0]  kind;
    logic        known;
    logic        now_zero;
    logic [63:0] now;
    logic [63:0] seq;
    logic        seq_zero;
    logic        seq_one;
    logic [3:0]  reason;
  } event_t;
endpackage
`default_nettype wire

>>> design/sls_if.sv
// valid/ready channel interfaces
`default_nettype none
interface sls_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [63:0] now_ns;
  logic [63:0] sequence_value;
  logic [3:0]  reason_code;
  modport source (output valid, req_type, now_ns, sequence_value, reason_code, input ready);
  modport sink (input valid, req_type, now_ns, sequence_value, reason_code, output ready);
endinterface

interface sls_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [2:0]  seq_status;
  logic [63:0] assigned_sequence;
  logic        keepalive_due;
  logic        timed_out;
  logic [2:0]  session_state;
  logic [3:0]  session_reason;
  logic [63:0] next_outbound_seq;
  logic [63:0] expected_inbound_seq;
  logic [31:0] state_change_count;
  modport source (output valid, accepted, seq_status, assigned_sequence, keepalive_due,
    timed_out, session_state, session_reason, next_outbound_seq, expected_inbound_seq,
    state_change_count, input ready);
  modport sink (input valid, accepted, seq_status, assigned_sequence, keepalive_due,
    timed_out, session_state, session_reason, next_outbound_seq, expected_inbound_seq,
    state_change_count, output ready);
endinterface

interface sls_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/sls_front.sv
// front end: accepts event words, classifies them and queues them
`default_nettype none
module sls_front
  import sls_pkg::*;
#(
  parameter int unsigned SEQ_WIDTH = SeqWidthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sls_in_if.sink    in_if,
  output event_t    ev_o,
  output logic      ev_valid_o,
  input  wire logic ev_pop_i
);
  localparam int unsigned PtrW = $clog2(QueueDepth);

  event_t           mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             push;
  event_t           ev_in;
  logic [63:0]      seq_mask;

  assign seq_mask = (SEQ_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << SEQ_WIDTH) - 64'd1);

  // classify the incoming word
  always_comb begin
    ev_in.kind     = in_if.req_type;
    ev_in.known    = in_if.req_type <= EV_HB_CHECK;
    ev_in.now      = in_if.now_ns;
    ev_in.now_zero = in_if.now_ns == 64'd0;
    ev_in.seq      = in_if.sequence_value & seq_mask;
    ev_in.seq_zero = ev_in.seq == 64'd0;
    ev_in.seq_one  = ev_in.seq == 64'd1;
    ev_in.reason   = in_if.reason_code;
  end

  assign in_if.ready = cnt_q != (PtrW+1)'(QueueDepth);
  assign push        = in_if.valid && in_if.ready;
  assign ev_valid_o  = cnt_q != '0;
  assign ev_o        = mem_q[rd_q];

  // queue pointers
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (ev_pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(ev_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= ev_in;
    end
  end
endmodule
`default_nettype wire

>>> design/sls_back.sv
// back end: session state machine, sequence counters and result register
`default_nettype none
module sls_back
  import sls_pkg::*;
#(
  parameter int unsigned SEQ_WIDTH = SeqWidthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sls_cfg_if.sink   cfg_if,
  input  event_t    ev_i,
  input  wire logic ev_valid_i,
  output logic      ev_pop_o,
  sls_out_if.source out_if
);
  `include "session_lifecycle_sequencer_top_defines.svh"

  localparam logic [SEQ_WIDTH-1:0] SeqMax = '1;

  logic [63:0] epoch_q, fence_q, hb_int_q, hb_tmo_q;
  sess_state_e st_q, st_d;
  logic [3:0]  rsn_q, rsn_d;
  logic [31:0] trans_q, trans_d;
  logic [SEQ_WIDTH-1:0] nout_q, nout_d, expin_q, expin_d, lastseq_q, lastseq_d;
  logic [63:0] lin_q, lin_d, lout_q, lout_d;
  logic        acc, tmo, hbd;
  logic [2:0]  sst;
  logic [63:0] asg;
  logic        init;
  logic [SEQ_WIDTH-1:0] sq;
  logic [63:0] now, in_gap, out_gap;
  logic        ov_q;

  assign cfg_if.ready = 1'b1;
  assign init = epoch_q != 0 && fence_q != 0 && hb_int_q != 0 && hb_tmo_q > hb_int_q;
  assign ev_pop_o = ev_valid_i && (!ov_q || out_if.ready);
  assign now = ev_i.now;
  assign sq = ev_i.seq[SEQ_WIDTH-1:0];
  assign in_gap = now - lin_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= '0; fence_q <= '0; hb_int_q <= '0; hb_tmo_q <= '0;
    end else if (cfg_if.valid && cfg_if.index[63:2] == '0) begin
      unique case (cfg_if.index[1:0])
        CFG_EPOCH:       epoch_q  <= cfg_if.data;
        CFG_FENCE:       fence_q  <= cfg_if.data;
        CFG_HB_INTERVAL: hb_int_q <= cfg_if.data;
        CFG_HB_TIMEOUT:  hb_tmo_q <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // event execution
  always_comb begin
    st_d = st_q; rsn_d = rsn_q; trans_d = trans_q;
    nout_d = nout_q; expin_d = expin_q; lastseq_d = lastseq_q;
    lin_d = lin_q; lout_d = lout_q;
    acc = 1'b0; sst = SQ_IN_ORDER; tmo = 1'b0; asg = '0;
    case (ev_i.kind)
      EV_LOGON_REQ: if (init && !ev_i.now_zero && st_q == ST_STOPPED) begin
        st_d = ST_LOGGING_ON; rsn_d = RS_OP_START; trans_d = trans_q + 32'd2; acc = 1'b1;
      end
      EV_LOGON_ACC: if (!ev_i.now_zero && st_q == ST_LOGGING_ON) begin
        lin_d = now; lout_d = now;
        st_d = ST_ACTIVE; rsn_d = RS_LOGON_ACC; trans_d = trans_q + 32'd1; acc = 1'b1;
      end
      EV_LOGOFF_REQ: if (!ev_i.now_zero && (st_q == ST_ACTIVE || st_q == ST_RECOVERING
                         || st_q == ST_HALTED)) begin
        st_d = ST_LOGGING_OFF; rsn_d = RS_OP_LOGOFF; trans_d = trans_q + 32'd1; acc = 1'b1;
      end
      EV_LOGOFF_DONE: if (!ev_i.now_zero && st_q == ST_LOGGING_OFF) begin
        st_d = ST_STOPPED; rsn_d = RS_LOGOFF_DONE; trans_d = trans_q + 32'd1; acc = 1'b1;
      end
      EV_REC_BEGIN: if (!ev_i.now_zero && (st_q == ST_ACTIVE || st_q == ST_HALTED)) begin
        st_d = ST_RECOVERING; rsn_d = ev_i.reason; trans_d = trans_q + 32'd1; acc = 1'b1;
      end
      EV_REC_DONE: if (!ev_i.now_zero && !ev_i.seq_zero && st_q == ST_RECOVERING) begin
        expin_d = sq;
        lastseq_d = (!ev_i.seq_one) ? sq - 1'b1 : '0;
        lin_d = now;
        st_d = ST_ACTIVE; rsn_d = RS_REC_DONE; trans_d = trans_q + 32'd1; acc = 1'b1;
      end
      EV_HALT: if (st_q != ST_STOPPED) begin
        st_d = ST_HALTED; rsn_d = ev_i.reason; trans_d = trans_q + 32'd1; acc = 1'b1;
      end
      EV_SHUTDOWN: begin
        st_d = ST_STOPPED; rsn_d = RS_SHUTDOWN; trans_d = trans_q + 32'd1; acc = 1'b1;
      end
      EV_CLAIM: begin
        if (st_q != ST_ACTIVE || ev_i.now_zero || now < lout_q) begin
          sst = SQ_INVALID;
        end else if (nout_q == '0) begin
          sst = SQ_EXHAUSTED;
          st_d = ST_HALTED; rsn_d = RS_SEQ_GAP; trans_d = trans_q + 32'd1;
        end else begin
          asg = 64'(nout_q);
          nout_d = (nout_q == SeqMax) ? '0 : nout_q + 1'b1;
          lout_d = now; acc = 1'b1;
        end
      end
      EV_OBSERVE: begin
        if ((st_q != ST_ACTIVE && st_q != ST_RECOVERING) || ev_i.now_zero || now < lin_q
            || ev_i.seq_zero || expin_q == '0) begin
          sst = SQ_INVALID;
        end else if (sq == lastseq_q) begin
          lin_d = now; sst = SQ_DUPLICATE;
        end else if (sq != expin_q) begin
          sst = (sq < expin_q) ? SQ_OUT_OF_ORDER : SQ_GAP;
          st_d = ST_HALTED; rsn_d = RS_SEQ_GAP; trans_d = trans_q + 32'd1;
        end else begin
          lastseq_d = sq;
          expin_d = (expin_q == SeqMax) ? '0 : expin_q + 1'b1;
          lin_d = now; acc = 1'b1;
          sst = ev_i.seq_one ? SQ_FIRST : SQ_IN_ORDER;
        end
      end
      EV_HB_CHECK: begin
        acc = 1'b1;
        if (st_q != ST_ACTIVE || now < lin_q) begin
          tmo = st_q == ST_HALTED;
        end else if (in_gap > hb_tmo_q) begin
          st_d = ST_HALTED; rsn_d = RS_HB_TIMEOUT; trans_d = trans_q + 32'd1; tmo = 1'b1;
        end
      end
      default: ;
    endcase
    if (!ev_i.known) acc = 1'b0;
  end

  assign out_gap = now - lout_d;
  assign hbd = st_d == ST_ACTIVE && now >= lout_d && out_gap >= hb_int_q;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_STOPPED; rsn_q <= RS_NONE; trans_q <= '0;
      nout_q <= SEQ_WIDTH'(1); expin_q <= SEQ_WIDTH'(1); lastseq_q <= '0;
      lin_q <= '0; lout_q <= '0;
    end else if (ev_pop_o) begin
      st_q <= st_d; rsn_q <= rsn_d; trans_q <= trans_d;
      nout_q <= nout_d; expin_q <= expin_d; lastseq_q <= lastseq_d;
      lin_q <= lin_d; lout_q <= lout_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ev_pop_o) begin
      ov_q <= 1'b1;
    end else if (out_if.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_pop_o) begin
      out_if.accepted             <= acc;
      out_if.seq_status           <= sst;
      out_if.assigned_sequence    <= asg;
      out_if.keepalive_due        <= hbd;
      out_if.timed_out            <= tmo;
      out_if.session_state        <= st_d;
      out_if.session_reason       <= rsn_d;
      out_if.next_outbound_seq    <= 64'(nout_d);
      out_if.expected_inbound_seq <= 64'(expin_d);
      out_if.state_change_count   <= trans_d;
    end
  end
  assign out_if.valid = ov_q;

  `SLS_ASSERT(a_no_pop_when_stalled, clk_i, rst_ni, !(ov_q && !out_if.ready && ev_pop_o),
    "event taken while result stalled")
  `SLS_ASSERT_NEXT(a_pop_gives_result, clk_i, rst_ni, ev_pop_o, ov_q,
    "result missing after event")
  `SLS_ASSERT_NEXT(a_trans_step, clk_i, rst_ni, ev_pop_o && st_d != st_q,
    trans_q != $past(trans_q), "state change without count")
endmodule
`default_nettype wire

>>> design/session_lifecycle_sequencer_top.sv
// Session lifecycle sequencer top level.
// An accepted event word is stored in the queue, then executed into the result register.
// One event per cycle while results are taken; the back end executes each combinationally.
// A two-entry queue parts front and back; the result register holds while stalled.
// Reset (asynchronous, active low) empties the queue, stops the session and
// clears the configuration registers.
`default_nettype none
module session_lifecycle_sequencer_top
  import sls_pkg::*;
#(
  parameter int unsigned SEQ_WIDTH = SeqWidthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sls_in_if.sink    in_if,
  sls_cfg_if.sink   cfg_if,
  sls_out_if.source out_if
);
  event_t ev;
  logic   ev_valid, ev_pop;

  sls_front #(.SEQ_WIDTH(SEQ_WIDTH)) u_front (
    .clk_i, .rst_ni, .in_if, .ev_o(ev), .ev_valid_o(ev_valid), .ev_pop_i(ev_pop)
  );

  sls_back #(.SEQ_WIDTH(SEQ_WIDTH)) u_back (
    .clk_i, .rst_ni, .cfg_if, .ev_i(ev), .ev_valid_i(ev_valid), .ev_pop_o(ev_pop), .out_if
  );
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// self-checking testbench of the session lifecycle sequencer top level
`default_nettype none
module tb;
  import sls_pkg::*;

  typedef struct {
    logic [3:0]  kind;
    logic [63:0] now;
    logic [63:0] seqv;
    logic [3:0]  rsn;
  } sess_event_t;

  typedef struct {
    logic        accepted;
    logic [2:0]  seq_status;
    logic [63:0] assigned;
    logic        hb_due;
    logic        timed_out;
    logic [2:0]  state;
    logic [3:0]  reason;
    logic [63:0] next_out;
    logic [63:0] exp_in;
    logic [31:0] trans;
  } snapshot_t;

  localparam logic [63:0] SeqAllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int LongHoldCycles = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sls_in_if  in_ch ();
  sls_cfg_if cfg_ch ();
  sls_out_if out_ch ();

  session_lifecycle_sequencer_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_ch),
    .cfg_if (cfg_ch),
    .out_if (out_ch)
  );

  always #5 clk = ~clk;

  // shadow of the session registers
  logic [63:0] epoch_r, fence_r, hb_int_r, hb_to_r;
  sess_state_e st_r;
  logic [3:0]  reason_r;
  logic [31:0] trans_r;
  logic [63:0] next_out_r, exp_in_r, last_in_seq_r, last_in_t_r, last_out_t_r;

  sess_event_t pending_events[$];
  snapshot_t   expected_snaps[$];
  int          mismatches = 0;

  // sender and receiver pacing controls
  bit          calm = 1'b0;
  bit          send_pause = 1'b0;
  int          long_hold_reqs = 0;

  // generator shadow counters
  logic [63:0] gen_now;
  logic [63:0] gen_in;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch on %s: got %h expected %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic move_to(input sess_state_e ns, input logic [3:0] rs, input logic [63:0] now);
    st_r = ns;
    reason_r = rs;
    trans_r = trans_r + 32'd1;
    if (ns == ST_ACTIVE && last_in_t_r == 64'd0) last_in_t_r = now;
  endtask

  function automatic bit cfg_ready_ok();
    return epoch_r != 0 && fence_r != 0 && hb_int_r != 0 && hb_to_r > hb_int_r;
  endfunction

  task automatic halt_session(input logic [3:0] rs, input logic [63:0] now, output bit took);
    took = 1'b0;
    if (st_r != ST_STOPPED) begin
      move_to(ST_HALTED, rs, now);
      took = 1'b1;
    end
  endtask

  // work out the snapshot that one event produces
  task automatic predict_snapshot(input sess_event_t e);
    snapshot_t s;
    bit took;
    logic [63:0] now;
    logic [63:0] sv;
    now = e.now;
    sv = e.seqv;
    s = '{default: '0};
    case (e.kind)
      EV_LOGON_REQ: if (cfg_ready_ok() && now != 0 && st_r == ST_STOPPED) begin
        move_to(ST_STARTING, RS_OP_START, now);
        move_to(ST_LOGGING_ON, RS_OP_START, now);
        s.accepted = 1'b1;
      end
      EV_LOGON_ACC: if (now != 0 && st_r == ST_LOGGING_ON) begin
        last_in_t_r = now;
        last_out_t_r = now;
        move_to(ST_ACTIVE, RS_LOGON_ACC, now);
        s.accepted = 1'b1;
      end
      EV_LOGOFF_REQ: if (now != 0 && (st_r == ST_ACTIVE || st_r == ST_RECOVERING ||
                                       st_r == ST_HALTED)) begin
        move_to(ST_LOGGING_OFF, RS_OP_LOGOFF, now);
        s.accepted = 1'b1;
      end
      EV_LOGOFF_DONE: if (now != 0 && st_r == ST_LOGGING_OFF) begin
        move_to(ST_STOPPED, RS_LOGOFF_DONE, now);
        s.accepted = 1'b1;
      end
      EV_REC_BEGIN: if (now != 0 && (st_r == ST_ACTIVE || st_r == ST_HALTED)) begin
        move_to(ST_RECOVERING, e.rsn, now);
        s.accepted = 1'b1;
      end
      EV_REC_DONE: if (now != 0 && sv != 0 && st_r == ST_RECOVERING) begin
        exp_in_r = sv;
        last_in_seq_r = (sv > 1) ? sv - 64'd1 : 64'd0;
        last_in_t_r = now;
        move_to(ST_ACTIVE, RS_REC_DONE, now);
        s.accepted = 1'b1;
      end
      EV_HALT: begin
        halt_session(e.rsn, now, took);
        s.accepted = took;
      end
      EV_SHUTDOWN: begin
        move_to(ST_STOPPED, RS_SHUTDOWN, now);
        s.accepted = 1'b1;
      end
      EV_CLAIM: begin
        if (st_r != ST_ACTIVE || now == 0 || now < last_out_t_r) begin
          s.seq_status = SQ_INVALID;
        end else if (next_out_r == 0) begin
          halt_session(RS_SEQ_GAP, now, took);
          s.seq_status = SQ_EXHAUSTED;
        end else begin
          s.assigned = next_out_r;
          next_out_r = (next_out_r == SeqAllOnes) ? 64'd0 : next_out_r + 64'd1;
          last_out_t_r = now;
          s.seq_status = SQ_IN_ORDER;
          s.accepted = 1'b1;
        end
      end
      EV_OBSERVE: begin
        if ((st_r != ST_ACTIVE && st_r != ST_RECOVERING) || now == 0 || now < last_in_t_r ||
            sv == 0 || exp_in_r == 0) begin
          s.seq_status = SQ_INVALID;
        end else if (sv == last_in_seq_r) begin
          last_in_t_r = now;
          s.seq_status = SQ_DUPLICATE;
        end else if (sv != exp_in_r) begin
          s.seq_status = (sv < exp_in_r) ? SQ_OUT_OF_ORDER : SQ_GAP;
          halt_session(RS_SEQ_GAP, now, took);
        end else begin
          last_in_seq_r = sv;
          exp_in_r = (exp_in_r == SeqAllOnes) ? 64'd0 : exp_in_r + 64'd1;
          last_in_t_r = now;
          s.seq_status = (sv == 64'd1) ? SQ_FIRST : SQ_IN_ORDER;
          s.accepted = 1'b1;
        end
      end
      EV_HB_CHECK: begin
        s.accepted = 1'b1;
        if (st_r != ST_ACTIVE || now < last_in_t_r) begin
          s.timed_out = (st_r == ST_HALTED);
        end else if (now - last_in_t_r > hb_to_r) begin
          halt_session(RS_HB_TIMEOUT, now, took);
          s.timed_out = 1'b1;
        end
      end
      default: ;
    endcase
    s.hb_due = (st_r == ST_ACTIVE && now >= last_out_t_r && now - last_out_t_r >= hb_int_r);
    s.state = st_r;
    s.reason = reason_r;
    s.next_out = next_out_r;
    s.exp_in = exp_in_r;
    s.trans = trans_r;
    expected_snaps.push_back(s);
  endtask

  // event driver: one offered word at a time, random gap before each unless calm
  bit sending = 1'b0;
  int send_gap = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.req_type <= '0;
      in_ch.now_ns <= '0;
      in_ch.sequence_value <= '0;
      in_ch.reason_code <= '0;
      sending = 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_snapshot(pending_events.pop_front());
        sending = 1'b0;
        send_gap = calm ? 0 : $urandom_range(0, 12);
      end
      if (!sending) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_events.size() > 0 && !send_pause) begin
          in_ch.req_type <= pending_events[0].kind;
          in_ch.now_ns <= pending_events[0].now;
          in_ch.sequence_value <= pending_events[0].seqv;
          in_ch.reason_code <= pending_events[0].rsn;
          sending = 1'b1;
        end
      end
      in_ch.valid <= sending;
    end
  end

  // result monitor with random and long stalls
  int recv_stall = 0;
  int long_hold = 0;
  int long_seen = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_snaps.size() == 0) begin
          report("result word with nothing expected", 64'd1, 64'd0);
        end else begin
          snapshot_t x;
          x = expected_snaps.pop_front();
          if (out_ch.accepted !== x.accepted) report("accepted", out_ch.accepted, x.accepted);
          if (out_ch.seq_status !== x.seq_status)
            report("seq_status", out_ch.seq_status, x.seq_status);
          if (out_ch.assigned_sequence !== x.assigned)
            report("assigned_sequence", out_ch.assigned_sequence, x.assigned);
          if (out_ch.keepalive_due !== x.hb_due)
            report("keepalive_due", out_ch.keepalive_due, x.hb_due);
          if (out_ch.timed_out !== x.timed_out)
            report("timed_out", out_ch.timed_out, x.timed_out);
          if (out_ch.session_state !== x.state)
            report("session_state", out_ch.session_state, x.state);
          if (out_ch.session_reason !== x.reason)
            report("session_reason", out_ch.session_reason, x.reason);
          if (out_ch.next_outbound_seq !== x.next_out)
            report("next_outbound_seq", out_ch.next_outbound_seq, x.next_out);
          if (out_ch.expected_inbound_seq !== x.exp_in)
            report("expected_inbound_seq", out_ch.expected_inbound_seq, x.exp_in);
          if (out_ch.state_change_count !== x.trans)
            report("state_change_count", out_ch.state_change_count, x.trans);
        end
        recv_stall = calm ? 0 : $urandom_range(0, 12);
      end
      if (long_seen != long_hold_reqs) begin
        long_seen = long_hold_reqs;
        long_hold = LongHoldCycles;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_ch.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_event(input logic [3:0] k, input logic [63:0] n, input logic [63:0] s,
                             input logic [3:0] r);
    sess_event_t e;
    e.kind = k;
    e.now = n;
    e.seqv = s;
    e.rsn = r;
    pending_events.push_back(e);
  endtask

  task automatic wait_drained();
    while (pending_events.size() > 0 || expected_snaps.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= 64'(idx);
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_EPOCH:       epoch_r = val;
      CFG_FENCE:       fence_r = val;
      CFG_HB_INTERVAL: hb_int_r = val;
      default:         hb_to_r = val;
    endcase
  endtask

  task automatic write_all(input logic [63:0] ep, input logic [63:0] fe, input logic [63:0] hi,
                           input logic [63:0] ht);
    write_reg(CFG_EPOCH, ep);
    write_reg(CFG_FENCE, fe);
    write_reg(CFG_HB_INTERVAL, hi);
    write_reg(CFG_HB_TIMEOUT, ht);
    @(posedge clk);
  endtask

  function automatic logic [63:0] step_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return gen_now - 64'($urandom_range(1, 50));
    if (r < 8) return gen_now + hb_to_r + 64'($urandom_range(1, 100));
    if (r < 12) return gen_now + hb_int_r;
    return gen_now + 64'($urandom_range(0, 400));
  endfunction

  // one well-formed session with random content and some damage
  task automatic queue_session(input int len);
    int r;
    logic [63:0] sv;
    gen_in = 64'd1;
    queue_event(EV_LOGON_REQ, gen_now, 64'd0, 4'($urandom));
    gen_now += 64'($urandom_range(1, 50));
    queue_event(EV_LOGON_ACC, gen_now, 64'd0, 4'($urandom));
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      gen_now = step_time();
      if (gen_now == 0) gen_now = 64'd1;
      if (r < 35) begin
        queue_event(EV_CLAIM, gen_now, rand64(), 4'($urandom));
      end else if (r < 70) begin
        r = $urandom_range(0, 19);
        if (r == 0) sv = gen_in + 64'($urandom_range(1, 3));
        else if (r == 1) sv = gen_in - 64'd1;
        else if (r == 2) sv = gen_in - 64'd2;
        else if (r == 3) sv = 64'd0;
        else if (r == 4) sv = rand64();
        else begin
          sv = gen_in;
          gen_in = gen_in + 64'd1;
        end
        queue_event(EV_OBSERVE, gen_now, sv, 4'($urandom));
      end else if (r < 82) begin
        queue_event(EV_HB_CHECK, gen_now, rand64(), 4'($urandom));
      end else if (r < 88) begin
        queue_event(EV_REC_BEGIN, gen_now, rand64(), 4'($urandom));
        gen_now += 64'd3;
        r = $urandom_range(0, 5);
        gen_in = (r == 0) ? SeqAllOnes - 64'($urandom_range(0, 2)) :
                 (r == 1) ? 64'd0 : 64'($urandom_range(1, 1000));
        queue_event(EV_REC_DONE, gen_now, gen_in, 4'($urandom));
      end else if (r < 91) begin
        queue_event(EV_HALT, gen_now, rand64(), 4'($urandom));
      end else if (r < 95) begin
        queue_event(4'($urandom_range(0, 15)), gen_now, rand64(), 4'($urandom));
      end else begin
        queue_event(4'($urandom_range(0, 15)), rand64(), rand64(), 4'($urandom));
      end
    end
    gen_now += 64'd5;
    if ($urandom_range(0, 3) == 0) begin
      queue_event(EV_SHUTDOWN, gen_now, 64'd0, 4'($urandom));
    end else begin
      queue_event(EV_LOGOFF_REQ, gen_now, 64'd0, 4'($urandom));
      queue_event(EV_LOGOFF_DONE, gen_now + 64'd1, 64'd0, 4'($urandom));
    end
    gen_now += 64'd10;
  endtask

  task automatic random_phase(input int items);
    int start;
    start = pending_events.size();
    while (pending_events.size() - start < items) queue_session($urandom_range(5, 60));
  endtask

  // stimulus sequence
  int drain_wait;
  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    epoch_r = 0; fence_r = 0; hb_int_r = 0; hb_to_r = 0;
    st_r = ST_STOPPED; reason_r = RS_NONE; trans_r = 0;
    next_out_r = 64'd1; exp_in_r = 64'd1; last_in_seq_r = 0;
    last_in_t_r = 0; last_out_t_r = 0;
    gen_now = 64'd100;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // not initialized: logon refused
    queue_event(EV_LOGON_REQ, 64'd10, 64'd0, 4'd0);
    queue_event(EV_HALT, 64'd10, 64'd0, 4'd9);
    wait_drained();
    write_all(64'd7, 64'd9, 64'd100, 64'd100);
    queue_event(EV_LOGON_REQ, 64'd20, 64'd0, 4'd0);
    wait_drained();

    // directed session through every event kind
    write_all(64'd7, 64'd9, 64'd100, 64'd500);
    queue_event(EV_LOGON_REQ, 64'd0, 64'd0, 4'd0);
    queue_event(EV_LOGON_REQ, 64'd50, 64'd0, 4'd0);
    queue_event(EV_LOGON_ACC, 64'd60, 64'd0, 4'd0);
    queue_event(EV_CLAIM, 64'd70, 64'd0, 4'd0);
    queue_event(EV_CLAIM, 64'd65, 64'd0, 4'd0);
    queue_event(EV_OBSERVE, 64'd80, 64'd1, 4'd0);
    queue_event(EV_OBSERVE, 64'd81, 64'd1, 4'd0);
    queue_event(EV_OBSERVE, 64'd82, 64'd2, 4'd0);
    queue_event(EV_OBSERVE, 64'd83, 64'd0, 4'd0);
    queue_event(EV_HB_CHECK, 64'd200, 64'd0, 4'd0);
    queue_event(EV_OBSERVE, 64'd210, 64'd9, 4'd0);
    queue_event(EV_HB_CHECK, 64'd220, 64'd0, 4'd0);
    queue_event(EV_REC_BEGIN, 64'd230, 64'd0, 4'd15);
    queue_event(EV_REC_DONE, 64'd240, SeqAllOnes, 4'd0);
    queue_event(EV_OBSERVE, 64'd250, SeqAllOnes, 4'd0);
    queue_event(EV_OBSERVE, 64'd251, 64'd1, 4'd0);
    queue_event(EV_HB_CHECK, 64'd2000, 64'd0, 4'd0);
    queue_event(EV_HALT, 64'd2001, 64'd0, 4'd12);
    queue_event(EV_LOGOFF_REQ, 64'd2002, 64'd0, 4'd0);
    queue_event(EV_LOGOFF_DONE, 64'd2003, 64'd0, 4'd0);
    queue_event(4'd11, SeqAllOnes, SeqAllOnes, 4'd15);
    queue_event(4'd15, 64'd1, 64'd1, 4'd1);
    queue_event(EV_SHUTDOWN, 64'd0, 64'd0, 4'd0);
    queue_event(EV_HALT, SeqAllOnes, 64'd0, 4'd3);
    wait_drained();

    // extreme register values
    write_all(SeqAllOnes, SeqAllOnes, SeqAllOnes - 64'd1, SeqAllOnes);
    gen_now = 64'd1000;
    random_phase(300);
    wait_drained();

    // small interval and timeout, long receiver hold-off while sending
    write_all(64'd1, 64'd1, 64'd1, 64'd2);
    calm = 1'b1;
    long_hold_reqs++;
    random_phase(400);
    wait_drained();

    // typical values, sender paused until drained midway
    calm = 1'b0;
    write_all(rand64(), rand64(), 64'd300, 64'd900);
    random_phase(300);
    send_pause = 1'b1;
    while (expected_snaps.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    send_pause = 1'b0;
    random_phase(300);
    wait_drained();

    // wide random register values and a timeout equal to the interval
    write_all(rand64(), rand64(), 64'($urandom_range(1, 800)), 64'($urandom_range(1, 1600)));
    random_phase(400);
    wait_drained();
    write_all(64'd3, 64'd4, 64'd500, 64'd500);
    random_phase(100);
    wait_drained();
    write_all(rand64(), rand64(), 64'd250, 64'd1000);
    long_hold_reqs++;
    random_phase(300);

    drain_wait = 0;
    while ((pending_events.size() > 0 || expected_snaps.size() > 0) && drain_wait < 200000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_snaps.size() == 0 && pending_events.size() == 0) begin
      $display("session_lifecycle_sequencer_top verification clean");
    end else begin
      $display("session_lifecycle_sequencer_top verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("session_lifecycle_sequencer_top verification failed");
    $finish;
  end
endmodule
`default_nettype wire
